[hdl/cus_pkg.sv]
// Shared widths, constants, payload types and control structs of the CPU utilization sampler.
package cus_pkg;

  localparam int IDX_W        = 8;
  localparam int TICK_W       = 64;
  localparam int PCT_W        = 7;
  localparam int MAX_CPUS_DEF = 256;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic [IDX_W-1:0]  cpu_index;
    logic              online;
    logic [TICK_W-1:0] tot_count;
    logic [TICK_W-1:0] busy_count;
    logic              sweep_last;
  } cus_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] sample_index;
    logic             index_ignored;
    logic [PCT_W-1:0] core_pct;
    logic [PCT_W-1:0] overall_percent;
    logic             sweep_done;
  } cus_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic delta;
    logic clamp;
    logic accum;
    logic div_start;
    logic div_sel_all;
    logic take_cpu;
    logic take_all;
    logic load_out;
  } cus_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic div_done;
  } cus_sts_t;

endpackage

[hdl/cus_ifs.sv]
// Valid/ready channel interfaces for sample and result transactions.
interface cus_in_if;
  import cus_pkg::*;
  logic    valid;
  logic    ready;
  cus_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cus_out_if;
  import cus_pkg::*;
  logic     valid;
  logic     ready;
  cus_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/cpu_utilization_sampler_core.sv]
// Top level of the CPU utilization sampler: controller plus datapath.
// One sample is handled at a time: a new one is accepted only after the previous one
//   has been loaded into the result register. Each sample waits on the 7-step quotient
//   loop of the shared percent divider, twice when it ends a sweep.
// Reset: synchronous; clears seen bits, sums and the first-sweep flag at once,
//   with no clearing pass over the counter memory.
module cpu_utilization_sampler_core #(
  parameter int MAX_CPUS = cus_pkg::MAX_CPUS_DEF
) (
  input logic clk,
  input logic rst,
  cus_in_if.sink    sample,
  cus_out_if.source result
);
  import cus_pkg::*;

  cus_cmd_t cmd;
  cus_sts_t sts;

  cus_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cus_datapath #(
    .MAX_CPUS (MAX_CPUS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .sample_data (sample.payload),
    .result_data (result.payload)
  );

endmodule

[hdl/cus_div.sv]
// Percent divider: floor(num*100/den), 0 when den is 0, else 100 when num >= den.
module cus_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cus_pkg::TICK_W-1:0] num,
  input  logic [cus_pkg::TICK_W-1:0] den,
  output logic                       done,
  output logic [cus_pkg::PCT_W-1:0]  quot
);
  import cus_pkg::*;

  localparam int NUM_W = TICK_W + PCT_W;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_LOAD = 4'b0010,
    D_ITER = 4'b0100,
    D_DONE = 4'b1000
  } div_state_t;

  div_state_t        state, state_next;
  logic [TICK_W-1:0] a_r, b_r, rem;
  logic [PCT_W-1:0]  nlo, q;
  logic [2:0]        cnt;
  logic              zero_f, sat_f;
  logic [NUM_W-1:0]  a_ext, n;
  logic [TICK_W:0]   trial, den_ext;
  logic              ge;

  // 100*a as 64a + 32a + 4a
  assign a_ext   = {{PCT_W{1'b0}}, a_r};
  assign n       = (a_ext << 6) + (a_ext << 5) + (a_ext << 2);
  assign trial   = {rem, nlo[cnt]};
  assign den_ext = {1'b0, b_r};
  assign ge      = trial >= den_ext;

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: if (start) state_next = D_LOAD;
      D_LOAD: state_next = D_ITER;
      D_ITER: if (cnt == 3'd0) state_next = D_ITER == state ? D_DONE : state;
      D_DONE: state_next = start ? D_LOAD : D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= num;
      b_r <= den;
    end
    if (state == D_LOAD) begin
      zero_f <= (b_r == '0);
      sat_f  <= (a_r >= b_r);
      // quotient is below 128, so the top bits already sit below den
      rem    <= n[NUM_W-1:PCT_W];
      nlo    <= n[PCT_W-1:0];
      q      <= '0;
      cnt    <= 3'(PCT_W - 1);
    end else if (state == D_ITER) begin
      rem    <= ge ? TICK_W'(trial - den_ext) : trial[TICK_W-1:0];
      q[cnt] <= ge;
      cnt    <= cnt - 3'd1;
    end
  end

  assign done = (state == D_DONE);
  assign quot = zero_f ? '0 : (sat_f ? PCT_FULL : q);

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == D_IDLE || state == D_DONE))
    else $error("divider started while busy");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    done |-> quot <= PCT_FULL)
    else $error("percent above full scale");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == D_LOAD))
    else $error("divider start not followed by load");

endmodule

[hdl/cus_datapath.sv]
// Datapath: counter memory, deltas, sweep sums, divider and result register.
module cus_datapath #(
  parameter int MAX_CPUS = cus_pkg::MAX_CPUS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cus_pkg::cus_cmd_t cmd,
  output cus_pkg::cus_sts_t sts,
  input  cus_pkg::cus_in_t  sample_data,
  output cus_pkg::cus_out_t result_data
);
  import cus_pkg::*;

  localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  logic [TICK_W-1:0] mem_total [MAX_CPUS];
  logic [TICK_W-1:0] mem_busy  [MAX_CPUS];
  logic [MAX_CPUS-1:0] prev_seen;

  cus_in_t           cur;
  logic              ignored;
  logic [TICK_W-1:0] rd_total, rd_busy;
  logic [TICK_W-1:0] dt, db;
  logic [TICK_W-1:0] sum_total, sum_busy;
  logic              first_sweep_done;
  logic [PCT_W-1:0]  cpu_pct, all_pct;
  cus_out_t          out_r;

  logic [AW-1:0]     rd_addr, cur_addr;
  logic              use_prev;
  logic [TICK_W-1:0] div_num, div_den;
  logic              div_done;
  logic [PCT_W-1:0]  div_quot;

  assign rd_addr  = sample_data.cpu_index[AW-1:0];
  assign cur_addr = cur.cpu_index[AW-1:0];
  assign use_prev = first_sweep_done && !ignored && prev_seen[cur_addr];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_total <= mem_total[rd_addr];
      rd_busy  <= mem_busy[rd_addr];
    end
    if (cmd.accum && !ignored) begin
      mem_total[cur_addr] <= cur.tot_count;
      mem_busy[cur_addr]  <= cur.busy_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= sample_data;
      ignored <= {1'b0, sample_data.cpu_index} >= (IDX_W + 1)'(MAX_CPUS);
      all_pct <= '0;
    end
    if (cmd.delta) begin
      dt <= use_prev ? cur.tot_count - rd_total : '0;
      db <= use_prev ? cur.busy_count - rd_busy : '0;
    end
    if (cmd.clamp && db > dt) begin
      db <= dt;
    end
    if (cmd.take_cpu) begin
      cpu_pct <= div_quot;
    end
    if (cmd.take_all) begin
      all_pct <= div_quot;
    end
    if (cmd.load_out) begin
      out_r.sample_index    <= cur.cpu_index;
      out_r.index_ignored   <= ignored;
      out_r.core_pct        <= cpu_pct;
      out_r.overall_percent <= all_pct;
      out_r.sweep_done      <= cur.sweep_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_seen        <= '0;
      first_sweep_done <= 1'b0;
      sum_total        <= '0;
      sum_busy         <= '0;
    end else begin
      if (cmd.accum && !ignored) begin
        prev_seen[cur_addr] <= 1'b1;
        if (cur.online) begin
          sum_total <= sum_total + dt;
          sum_busy  <= sum_busy + db;
        end
      end
      // sweep ends: restart the sums
      if (cmd.take_all) begin
        sum_total        <= '0;
        sum_busy         <= '0;
        first_sweep_done <= 1'b1;
      end
    end
  end

  assign div_num = cmd.div_sel_all ? sum_busy : db;
  assign div_den = cmd.div_sel_all ? sum_total : dt;

  cus_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign sts.last     = cur.sweep_last;
  assign sts.div_done = div_done;
  assign result_data  = out_r;

endmodule

[hdl/cus_ctrl.sv]
// Controller state machine sequencing one sample through the datapath.
module cus_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cus_pkg::cus_sts_t sts,
  output cus_pkg::cus_cmd_t cmd
);
  import cus_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DELTA   = 7'b0000010,
    S_CLAMP   = 7'b0000100,
    S_ACCUM   = 7'b0001000,
    S_DIV_CPU = 7'b0010000,
    S_DIV_ALL = 7'b0100000,
    S_FINISH  = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic        slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum     = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_DIV_CPU;
      end
      S_DIV_CPU: begin
        if (sts.div_done) begin
          cmd.take_cpu = 1'b1;
          if (sts.last) begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_all = 1'b1;
            state_next      = S_DIV_ALL;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_DIV_ALL: begin
        cmd.div_sel_all = 1'b1;
        if (sts.div_done) begin
          cmd.take_all = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register can take this transaction
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> slot_free)
    else $error("result overwritten before transfer");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DIV_CPU || state == S_DIV_ALL))
    else $error("divider finished outside a wait state");

  a_overall_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_ALL) |-> sts.last)
    else $error("overall share computed without sweep end");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DELTA))
    else $error("accepted sample not processed");

endmodule
